// File: hw/rtl/ziplist_entry_decoder_top_defines.svh
// Assertion macros shared by the decoder checker.
// Depends on nothing; included by the checker file.
`ifndef ZIPLIST_ENTRY_DECODER_TOP_DEFINES_SVH
`define ZIPLIST_ENTRY_DECODER_TOP_DEFINES_SVH
`define ZED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ZED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/zed_pkg.sv
// Package for the compact-list entry decoder: payload types and codes.
// Depends on nothing.
`default_nettype none
package zed_pkg;
	localparam logic [2:0] KIND_STR   = 3'd0;
	localparam logic [2:0] KIND_EMPTY = 3'd1;
	localparam logic [2:0] KIND_INT   = 3'd2;
	localparam logic [2:0] KIND_END   = 3'd3;
	localparam logic [2:0] KIND_BAD   = 3'd4;
	localparam logic [7:0] NIBBLE_MASK = 8'h0f;
	localparam logic [7:0] BYTE_END    = 8'hff;
	localparam logic [7:0] BYTE_LONG   = 8'hfe;

	typedef struct packed {
		logic [7:0] blob_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         text_byte;
		logic signed [63:0] int_value;
		logic               entry_done;
		logic               is_value;
	} out_item_t;

	// Queued request from the front part to the back part.
	typedef struct packed {
		logic [7:0] blob_byte;
		logic       first_byte;
	} req_t;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_START = 7'b0000010,
		PH_SKIP  = 7'b0000100,
		PH_ENC   = 7'b0001000,
		PH_LEN   = 7'b0010000,
		PH_STR   = 7'b0100000,
		PH_INT   = 7'b1000000
	} phase_t;

	function automatic logic [3:0] int_size(input logic [7:0] enc);
		logic [3:0] n;
		case (enc)
			8'hc0: n = 4'd2;
			8'hd0: n = 4'd4;
			8'he0: n = 4'd8;
			8'hf0: n = 4'd3;
			8'hfe: n = 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/zed_front.sv
// Front part: takes input requests and queues them in a two-entry FIFO.
// Depends on zed_pkg.
`default_nettype none
module zed_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire zed_pkg::in_item_t in_item,
	output logic                  q_valid,
	input  wire logic             q_pop,
	output zed_pkg::req_t         q_req
);
	import zed_pkg::*;

	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{blob_byte: in_item.blob_byte, first_byte: in_item.first_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/zed_back.sv
// Back part: parses queued bytes and drives a registered result slot.
// Depends on zed_pkg.
`default_nettype none
module zed_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pair_mode,
	input  wire logic               q_valid,
	output logic                    q_pop,
	input  wire zed_pkg::req_t      q_req,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output zed_pkg::out_item_t      out_item
);
	import zed_pkg::*;

	phase_t     phase_q;
	logic [3:0] cnt_q;
	logic [7:0] enc_q;
	logic [31:0] len_q;
	logic [63:0] acc_q;
	logic       role_q;
	logic       ov_q;
	out_item_t  res_q;

	phase_t     ph, ph_n;
	logic [3:0] cnt, cnt_n;
	logic [7:0] enc, enc_n, b;
	logic [31:0] len, len_n;
	logic [63:0] acc, acc_n, sx;
	logic       role, role_n;
	logic       emit, ent;
	out_item_t  r;
	logic [3:0] n;

	assign q_pop     = q_valid && (!ov_q || !out_stall);
	assign out_valid = ov_q;
	assign out_item  = res_q;

	always_comb begin
		b = q_req.blob_byte;
		if (q_req.first_byte) begin
			ph = PH_START; cnt = '0; enc = '0; len = '0; acc = '0; role = 1'b0;
		end else begin
			ph = phase_q; cnt = cnt_q; enc = enc_q; len = len_q; acc = acc_q; role = role_q;
		end
		ph_n = ph; cnt_n = cnt; enc_n = enc; len_n = len; acc_n = acc; role_n = role;
		emit = 1'b0; ent = 1'b0;
		r = '0;
		n = int_size(enc);
		sx = '0;
		case (ph)
			PH_START: begin
				if (b == BYTE_END) begin
					ph_n = PH_IDLE; emit = 1'b1; r.kind = KIND_END; r.entry_done = 1'b1;
				end else if (b == BYTE_LONG) begin
					cnt_n = 4'd4; ph_n = PH_SKIP;
				end else begin
					ph_n = PH_ENC;
				end
			end
			PH_SKIP: begin
				cnt_n = cnt - 4'd1;
				if (cnt_n == 4'd0) ph_n = PH_ENC;
			end
			PH_ENC: begin
				enc_n = b;
				case (b[7:6])
					2'b00: begin
						len_n = {26'd0, b[5:0]};
						if (b[5:0] == 6'd0) begin
							emit = 1'b1; ent = 1'b1; r.kind = KIND_EMPTY; r.entry_done = 1'b1;
						end else begin
							ph_n = PH_STR;
						end
					end
					2'b01: begin
						len_n = {18'd0, b[5:0], 8'd0}; cnt_n = 4'd1; ph_n = PH_LEN;
					end
					2'b10: begin
						len_n = '0; cnt_n = 4'd4; ph_n = PH_LEN;
					end
					default: begin
						if (b inside {[8'hf1:8'hfd]}) begin
							emit = 1'b1; ent = 1'b1; r.kind = KIND_INT; r.entry_done = 1'b1;
							r.int_value = {60'd0, (b[3:0] & NIBBLE_MASK[3:0]) - 4'd1};
						end else if (int_size(b) != 4'd0) begin
							acc_n = '0; cnt_n = '0; ph_n = PH_INT;
						end else begin
							ph_n = PH_IDLE; emit = 1'b1; r.kind = KIND_BAD; r.entry_done = 1'b1;
						end
					end
				endcase
			end
			PH_LEN: begin
				if (enc[7:6] == 2'b01) len_n = len | {24'd0, b};
				else len_n = {len[23:0], b};
				cnt_n = cnt - 4'd1;
				if (cnt_n == 4'd0) begin
					if (len_n == 32'd0) begin
						emit = 1'b1; ent = 1'b1; r.kind = KIND_EMPTY; r.entry_done = 1'b1;
					end else begin
						ph_n = PH_STR;
					end
				end
			end
			PH_STR: begin
				len_n = len - 32'd1;
				emit = 1'b1; ent = 1'b1; r.kind = KIND_STR; r.text_byte = b;
				r.entry_done = (len_n == 32'd0);
			end
			PH_INT: begin
				if (n == 4'd0 || cnt >= 4'd8) begin
					ph_n = PH_IDLE; emit = 1'b1; r.kind = KIND_BAD; r.entry_done = 1'b1;
				end else begin
					acc_n = acc | ({56'd0, b} << {cnt[2:0], 3'b000});
					cnt_n = cnt + 4'd1;
					if (cnt_n >= n) begin
						case (n)
							4'd1: sx = {{56{acc_n[7]}}, acc_n[7:0]};
							4'd2: sx = {{48{acc_n[15]}}, acc_n[15:0]};
							4'd3: sx = {{40{acc_n[23]}}, acc_n[23:0]};
							4'd4: sx = {{32{acc_n[31]}}, acc_n[31:0]};
							default: sx = acc_n;
						endcase
						emit = 1'b1; ent = 1'b1; r.kind = KIND_INT; r.entry_done = 1'b1;
						r.int_value = sx;
					end
				end
			end
			default: ;
		endcase
		r.is_value = ent && pair_mode && role;
		if (ent && r.entry_done) begin
			role_n = !role; ph_n = PH_START;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; cnt_q <= '0; enc_q <= '0; len_q <= '0;
			acc_q <= '0; role_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= ph_n; cnt_q <= cnt_n; enc_q <= enc_n; len_q <= len_n;
				acc_q <= acc_n; role_q <= role_n;
				ov_q <= emit;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/ziplist_entry_decoder_top.sv
// Top level of the compact-list entry decoder: front queue and back parser.
// Depends on zed_pkg, zed_front and zed_back.
// Path: an accepted byte is queued in the front FIFO, then parsed into the back part's registered result slot.
// Throughput: one byte per cycle while neither side stalls; the back parser updates its state on each popped byte.
// Reset clears the queue, the parser state and pair_mode.
`default_nettype none
module ziplist_entry_decoder_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire zed_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output zed_pkg::out_item_t      out_item
);
	import zed_pkg::*;

	logic pair_mode_q;
	logic q_valid, q_pop;
	req_t q_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pair_mode_q <= 1'b0;
		else if (cfg_we) pair_mode_q <= cfg_wdata;
	end

	zed_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_pop, .q_req
	);

	zed_back u_back (
		.clk, .arst_n, .pair_mode(pair_mode_q), .q_valid, .q_pop, .q_req,
		.out_valid, .out_stall, .out_item
	);
endmodule
`default_nettype wire

// File: hw/rtl/zed_checker.sv
// Port-level checker for the decoder, bound to the top level.
// Depends on zed_pkg and the assertion macro header.
`default_nettype none
`include "ziplist_entry_decoder_top_defines.svh"
module zed_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire zed_pkg::out_item_t out_item
);
	import zed_pkg::*;

	`ZED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`ZED_ASSERT_IMPL(a_kind_range, clk, arst_n, out_valid, out_item.kind <= KIND_BAD)
	`ZED_ASSERT_IMPL(a_close_done, clk, arst_n, out_valid && out_item.kind >= KIND_END, out_item.entry_done && !out_item.is_value)
	`ZED_ASSERT_IMPL(a_empty_done, clk, arst_n, out_valid && out_item.kind == KIND_EMPTY, out_item.entry_done)
endmodule

bind ziplist_entry_decoder_top zed_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_item
);
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the compact-list entry decoder top level.
// Depends on zed_pkg and ziplist_entry_decoder_top; predicts each result and
// compares it with the block's output under random idling on both channels.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import zed_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		P_IDLE, P_START, P_SKIP, P_ENC, P_LEN, P_STR, P_INT
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	parse_phase_t dec_phase;
	logic [3:0] dec_count;
	logic [7:0] dec_enc;
	logic [31:0] dec_remaining;
	logic [63:0] dec_acc;
	logic dec_role;
	logic dec_pair_mode;

	out_item_t pending_results[$];
	int error_count = 0;
	int result_count = 0;
	int request_count = 0;
	int idle_cycles = 0;

	ziplist_entry_decoder_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always #1 clk = ~clk;

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 25);
	endfunction

	function automatic logic [3:0] width_of(logic [7:0] enc);
		case (enc)
			8'hc0: return 4'd2;
			8'hd0: return 4'd4;
			8'he0: return 4'd8;
			8'hf0: return 4'd3;
			8'hfe: return 4'd1;
			default: return 4'd0;
		endcase
	endfunction

	task automatic clear_decoder();
		dec_phase = P_START;
		dec_count = '0;
		dec_enc = '0;
		dec_remaining = '0;
		dec_acc = '0;
		dec_role = 1'b0;
	endtask

	task automatic push_result(logic [2:0] kind, logic [7:0] text, logic [63:0] ival,
			logic done, logic entry_result);
		out_item_t r;
		r.kind = kind;
		r.text_byte = text;
		r.int_value = ival;
		r.entry_done = done;
		r.is_value = (entry_result && dec_pair_mode) ? dec_role : 1'b0;
		pending_results.insert(pending_results.size(), r);
		if (entry_result && done) begin
			dec_role = ~dec_role;
			dec_phase = P_START;
		end
	endtask

	task automatic string_length_known();
		if (dec_remaining == 0) begin
			push_result(KIND_EMPTY, 8'h00, 64'd0, 1'b1, 1'b1);
		end else begin
			dec_phase = P_STR;
		end
	endtask

	task automatic decode_byte(in_item_t it);
		logic [7:0] b;
		logic [3:0] n;
		logic [63:0] v;
		logic [63:0] mask;
		b = it.blob_byte;
		if (it.first_byte) begin
			clear_decoder();
		end
		case (dec_phase)
			P_START: begin
				if (b == BYTE_END) begin
					dec_phase = P_IDLE;
					push_result(KIND_END, 8'h00, 64'd0, 1'b1, 1'b0);
				end else if (b == BYTE_LONG) begin
					dec_count = 4'd4;
					dec_phase = P_SKIP;
				end else begin
					dec_phase = P_ENC;
				end
			end
			P_SKIP: begin
				dec_count = dec_count - 4'd1;
				if (dec_count == 0) begin
					dec_phase = P_ENC;
				end
			end
			P_ENC: begin
				dec_enc = b;
				case (b[7:6])
					2'b00: begin
						dec_remaining = {26'd0, b[5:0]};
						string_length_known();
					end
					2'b01: begin
						dec_remaining = {18'd0, b[5:0], 8'd0};
						dec_count = 4'd1;
						dec_phase = P_LEN;
					end
					2'b10: begin
						dec_remaining = '0;
						dec_count = 4'd4;
						dec_phase = P_LEN;
					end
					default: begin
						if (b >= 8'hf1 && b <= 8'hfd) begin
							v = {56'd0, b & NIBBLE_MASK} - 64'd1;
							push_result(KIND_INT, 8'h00, v, 1'b1, 1'b1);
						end else if (width_of(b) != 0) begin
							dec_acc = '0;
							dec_count = '0;
							dec_phase = P_INT;
						end else begin
							dec_phase = P_IDLE;
							push_result(KIND_BAD, 8'h00, 64'd0, 1'b1, 1'b0);
						end
					end
				endcase
			end
			P_LEN: begin
				if (dec_enc[7:6] == 2'b01) begin
					dec_remaining = dec_remaining | {24'd0, b};
				end else begin
					dec_remaining = {dec_remaining[23:0], b};
				end
				dec_count = dec_count - 4'd1;
				if (dec_count == 0) begin
					string_length_known();
				end
			end
			P_STR: begin
				dec_remaining = dec_remaining - 32'd1;
				push_result(KIND_STR, b, 64'd0, dec_remaining == 0, 1'b1);
			end
			P_INT: begin
				n = width_of(dec_enc);
				if (n == 0 || dec_count >= 4'd8) begin
					dec_phase = P_IDLE;
					push_result(KIND_BAD, 8'h00, 64'd0, 1'b1, 1'b0);
				end else begin
					dec_acc = dec_acc | ({56'd0, b} << (8 * dec_count));
					dec_count = dec_count + 4'd1;
					if (dec_count >= n) begin
						v = dec_acc;
						if (n < 8) begin
							mask = (64'd1 << (8 * n)) - 64'd1;
							v = v & mask;
							if (v[8 * n - 1]) begin
								v = v | ~mask;
							end
						end
						push_result(KIND_INT, 8'h00, v, 1'b1, 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_byte(logic [7:0] b, logic first);
		in_item_t it;
		int gap;
		gap = random_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.blob_byte = b;
		it.first_byte = first;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(it);
		request_count++;
	endtask

	task automatic write_pair_mode(logic value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		dec_pair_mode = value;
	endtask

	task automatic send_random_entry();
		int sel;
		int len;
		logic [7:0] enc;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			send_byte(BYTE_LONG, 1'b0);
			repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_byte(8'($urandom_range(0, 253)), 1'b0);
		end
		if (sel < 30) begin
			len = $urandom_range(0, 6);
			send_byte({2'b00, 6'(len)}, 1'b0);
			repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (sel < 38) begin
			len = $urandom_range(0, 5);
			send_byte(8'h40, 1'b0);
			send_byte(8'(len), 1'b0);
			repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (sel < 44) begin
			len = $urandom_range(0, 4);
			send_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
			send_byte(8'h00, 1'b0);
			send_byte(8'h00, 1'b0);
			send_byte(8'h00, 1'b0);
			send_byte(8'(len), 1'b0);
			repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (sel < 58) begin
			send_byte(8'($urandom_range(8'hf1, 8'hfd)), 1'b0);
		end else begin
			case ($urandom_range(0, 4))
				0: enc = 8'hc0;
				1: enc = 8'hd0;
				2: enc = 8'he0;
				3: enc = 8'hf0;
				default: enc = 8'hfe;
			endcase
			send_byte(enc, 1'b0);
			repeat (width_of(enc)) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic test_directed();
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hfd, 1'b0);
		send_byte(8'hfe, 1'b0);
		repeat (4) send_byte(8'hff, 1'b0);
		send_byte(8'hf1, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'hf0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hfd, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hc1, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_wide_lengths();
		send_byte(8'h00, 1'b1);
		send_byte(8'h7f, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hfe, 1'b1);
		repeat (4) send_byte(8'h00, 1'b0);
		send_byte(8'hbf, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
	endtask

	task automatic test_integers();
		logic [7:0] encs[5];
		encs = '{8'hc0, 8'hd0, 8'he0, 8'hf0, 8'hfe};
		send_byte(8'h00, 1'b1);
		foreach (encs[i]) begin
			send_byte(8'h01, 1'b0);
			send_byte(encs[i], 1'b0);
			repeat (width_of(encs[i])) send_byte(8'hff, 1'b0);
			send_byte(8'h00, 1'b0);
			send_byte(encs[i], 1'b0);
			repeat (width_of(encs[i]) - 1) send_byte(8'h00, 1'b0);
			send_byte(8'h80, 1'b0);
		end
		send_byte(8'hff, 1'b0);
	endtask

	task automatic test_random_lists(int n_bytes);
		int start;
		int entries;
		start = request_count;
		while (request_count - start < n_bytes) begin
			send_byte(8'($urandom_range(0, 253)), 1'b1);
			send_byte(8'($urandom_range(0, 2)), 1'b0);
			entries = $urandom_range(0, 8);
			for (int e = 0; e < entries; e++) begin
				send_random_entry();
			end
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				1: send_byte(8'hc1 + 8'($urandom_range(0, 14)), 1'b0);
				default: send_byte(BYTE_END, 1'b0);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= (random_gap() != 0);
			if (out_valid && !out_stall) begin
				result_count++;
				if (pending_results.size() == 0) begin
					$error("unexpected result kind=%0d", out_item.kind);
					error_count++;
				end else begin
					automatic out_item_t e = pending_results.pop_front();
					if (out_item.kind !== e.kind) begin
						$error("kind expected %0d actual %0d", e.kind, out_item.kind);
						error_count++;
					end
					if (out_item.text_byte !== e.text_byte) begin
						$error("text_byte expected %0h actual %0h", e.text_byte,
							out_item.text_byte);
						error_count++;
					end
					if (out_item.int_value !== e.int_value) begin
						$error("int_value expected %0d actual %0d", e.int_value,
							out_item.int_value);
						error_count++;
					end
					if (out_item.entry_done !== e.entry_done) begin
						$error("entry_done expected %0d actual %0d", e.entry_done,
							out_item.entry_done);
						error_count++;
					end
					if (out_item.is_value !== e.is_value) begin
						$error("is_value expected %0d actual %0d", e.is_value,
							out_item.is_value);
						error_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("watchdog expired after %0d cycles without a request", idle_cycles);
				$display("Sent %0d bytes and checked %0d results before the run stalled.",
					request_count, result_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		dec_pair_mode = 1'b0;
		clear_decoder();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wide_lengths();
		test_integers();
		write_pair_mode(1'b1);
		test_directed();
		test_random_lists(700);
		write_pair_mode(1'b0);
		test_integers();
		test_random_lists(500);
		write_pair_mode(1'b1);
		test_random_lists(300);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes and checked %0d results across both list modes.",
			request_count, result_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/zed_pkg.sv
hw/rtl/zed_front.sv
hw/rtl/zed_back.sv
hw/rtl/ziplist_entry_decoder_top.sv
hw/rtl/zed_checker.sv
dv/testbench.sv
